/* src/chvp_pkg.sv */
// Types and constants shared by the chunk header varint parser.
`timescale 1ns / 1ps

package chvp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned AccW     = 32;
  localparam int unsigned ValueW   = 33;
  localparam int unsigned KindW    = 4;
  localparam int unsigned CodeW    = 2;
  localparam int unsigned CntW     = 3;
  localparam int unsigned TdataOutW = 40;

  localparam logic [ByteW-1:0] PacketIdReset = 8'd58;
  localparam logic [ByteW-1:0] PayloadMask   = 8'h7f;
  localparam logic [ByteW-1:0] ContMask      = 8'h80;
  localparam logic [CntW-1:0]  MaxVarintBytes = 3'd5;

  typedef enum logic [2:0] {
    PH_X     = 3'd0,
    PH_Z     = 3'd1,
    PH_DIM   = 3'd2,
    PH_COUNT = 3'd3,
    PH_CACHE = 3'd4,
    PH_LEN   = 3'd5,
    PH_DATA  = 3'd6,
    PH_DONE  = 3'd7
  } phase_t;

  typedef enum logic [KindW-1:0] {
    KIND_X      = 4'd0,
    KIND_Z      = 4'd1,
    KIND_DIM    = 4'd2,
    KIND_COUNT  = 4'd3,
    KIND_CACHE  = 4'd4,
    KIND_LEN    = 4'd5,
    KIND_DATA   = 4'd6,
    KIND_END    = 4'd7,
    KIND_ERROR  = 4'd8
  } kind_t;

  typedef enum logic [CodeW-1:0] {
    ERR_NONE     = 2'd0,
    ERR_OVERLONG = 2'd1,
    ERR_EARLY    = 2'd2,
    ERR_SHORT    = 2'd3
  } err_t;

  typedef struct packed {
    phase_t            phase;
    logic              at_start;
    logic [AccW-1:0]   acc;
    logic [CntW-1:0]   cnt;
    logic [AccW-1:0]   left;
    logic              err_latched;
  } state_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [ValueW-1:0] value;
    err_t              code;
    logic              last;
  } result_t;

  localparam state_t StateReset = '{
    phase:       PH_X,
    at_start:    1'b1,
    acc:         '0,
    cnt:         '0,
    left:        '0,
    err_latched: 1'b0
  };

endpackage

/* src/chunk_header_varint_parser.sv */
// Top level: byte stream in, decoded header fields and data bytes out.
//
//  channel   dir  tdata                              tuser         tlast
//  s_axis    in   [7:0] in_byte                      -             last_byte
//  m_axis    out  [32:0] field_value,[34:33] code    [3:0] kind    end_of_packet
//  cfg_wr    in   [7:0] packet_id                    -             -
//
// One byte per cycle; a result appears in the cycle after its byte is accepted.
// Parser state and the result register update in the same edge, so back-to-back
// beats run at full rate. s_axis_tready drops only while a result is stalled.
// rst (synchronous) clears parser state, output valid and restores packet_id to 58.
// Bytes that give no result (mid-varint, skipped id, dropped tail) leave no beat.
`timescale 1ns / 1ps

module chunk_header_varint_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,     // packet_id
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] in_byte
  input  logic        s_axis_tlast,    // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,    // [32:0] field_value, [34:33] error_code, rest zero
  output logic [3:0]  m_axis_tuser,    // [3:0] field_kind
  output logic        m_axis_tlast     // end_of_packet
);
  import chvp_pkg::*;

  state_t           state;
  state_t           state_next;
  result_t          step_result;
  logic [ByteW-1:0] packet_id;
  logic             in_beat;

  logic [ValueW-1:0] out_value;
  err_t              out_code;
  kind_t             out_kind;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  chvp_step u_step (
    .state      (state),
    .in_byte    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .packet_id  (packet_id),
    .state_next (state_next),
    .result     (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_id <= PacketIdReset;
    end else if (cfg_wr_en) begin
      packet_id <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= StateReset;
      m_axis_tvalid <= 1'b0;
    end else if (in_beat) begin
      state         <= state_next;
      m_axis_tvalid <= step_result.valid;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_beat && step_result.valid) begin
      out_value    <= step_result.value;
      out_code     <= step_result.code;
      out_kind     <= step_result.kind;
      m_axis_tlast <= step_result.last;
    end
  end

  assign m_axis_tdata = {{(TdataOutW - ValueW - CodeW){1'b0}}, out_code, out_value};
  assign m_axis_tuser = out_kind;

endmodule

/* src/chvp_step.sv */
// Per-byte decode: next parser state and the result for one input beat.
`timescale 1ns / 1ps

module chvp_step (
  input  chvp_pkg::state_t          state,
  input  logic [7:0]                in_byte,
  input  logic                      in_last,
  input  logic [7:0]                packet_id,
  output chvp_pkg::state_t          state_next,
  output chvp_pkg::result_t         result
);
  import chvp_pkg::*;

  logic [AccW-1:0]   byte_shifted;
  logic [AccW-1:0]   acc_or;
  logic [AccW-1:0]   zigzag;
  logic [AccW-1:0]   left_dec;
  logic [CntW-1:0]   cnt_inc;
  logic              skip;
  err_t              tail_code;
  logic [ByteW-1:0]  payload;

  assign payload  = in_byte & PayloadMask;
  assign acc_or   = state.acc | byte_shifted;
  assign zigzag   = (acc_or >> 1) ^ {AccW{acc_or[0]}};
  assign left_dec = state.left - AccW'(1);
  assign cnt_inc  = state.cnt + CntW'(1);
  assign skip     = state.at_start && (in_byte == packet_id);

  // 7-bit group placed at 7*count; bits above 31 fall off
  always_comb begin
    case (state.cnt)
      3'd0:    byte_shifted = AccW'(payload);
      3'd1:    byte_shifted = AccW'(payload) << 7;
      3'd2:    byte_shifted = AccW'(payload) << 14;
      3'd3:    byte_shifted = AccW'(payload) << 21;
      3'd4:    byte_shifted = AccW'(payload) << 28;
      default: byte_shifted = '0;
    endcase
  end

  always_comb begin
    state_next   = state;
    result       = '0;
    result.kind  = KIND_END;
    result.code  = ERR_NONE;
    result.last  = in_last;
    tail_code    = ERR_NONE;

    if (state.err_latched) begin
      // swallow the rest of a failed packet silently
      if (in_last) begin
        state_next = StateReset;
      end
    end else begin
      state_next.at_start = 1'b0;
      if (!skip) begin
        case (state.phase)
          PH_CACHE: begin
            result.valid     = 1'b1;
            result.kind      = KIND_CACHE;
            result.value     = ValueW'(in_byte != '0);
            state_next.phase = PH_LEN;
          end
          PH_DATA: begin
            result.valid     = 1'b1;
            result.kind      = KIND_DATA;
            result.value     = ValueW'(in_byte);
            state_next.left  = left_dec;
            if (left_dec == '0) begin
              state_next.phase = PH_DONE;
            end
          end
          PH_DONE: begin
          end
          default: begin
            if ((in_byte & ContMask) == '0) begin
              result.valid   = 1'b1;
              result.kind    = kind_t'({1'b0, state.phase});
              if (state.phase == PH_X || state.phase == PH_Z || state.phase == PH_DIM) begin
                result.value = {zigzag[AccW-1], zigzag};
              end else begin
                result.value = {1'b0, acc_or};
              end
              state_next.acc = '0;
              state_next.cnt = '0;
              if (state.phase == PH_LEN) begin
                state_next.left  = acc_or;
                state_next.phase = (acc_or == '0) ? PH_DONE : PH_DATA;
              end else begin
                state_next.phase = phase_t'(state.phase + 3'd1);
              end
            end else begin
              state_next.acc = acc_or;
              state_next.cnt = cnt_inc;
              if (cnt_inc >= MaxVarintBytes) begin
                result.valid           = 1'b1;
                result.kind            = KIND_ERROR;
                result.value           = '0;
                result.code            = ERR_OVERLONG;
                state_next.err_latched = 1'b1;
              end
            end
          end
        endcase
      end

      if (in_last) begin
        if (result.code == ERR_NONE) begin
          if (state_next.phase == PH_DATA) begin
            tail_code = ERR_SHORT;
          end else if (state_next.phase == PH_DONE) begin
            tail_code = ERR_NONE;
          end else begin
            tail_code = ERR_EARLY;
          end
          result.code = tail_code;
          if (!result.valid) begin
            result.valid = 1'b1;
            result.kind  = (tail_code == ERR_NONE) ? KIND_END : KIND_ERROR;
            result.value = '0;
          end
        end
        state_next = StateReset;
      end
    end
  end

endmodule

/* src/chvp_checker.sv */
// Port-level checks for the chunk header varint parser, bound to the top level.
`timescale 1ns / 1ps

module chvp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import chvp_pkg::*;

  // a stalled result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // end and error beats carry a zero value; error beats carry a nonzero code
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KIND_ERROR) |->
      (m_axis_tdata[34:33] != ERR_NONE) && (m_axis_tdata[32:0] == '0))
    else $error("error beat without code or with value");

  a_end_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KIND_END) |->
      m_axis_tlast && (m_axis_tdata[34:33] == ERR_NONE) && (m_axis_tdata[32:0] == '0))
    else $error("end beat malformed");

  // truncation codes only come with the final byte
  a_trunc_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[34:33] == ERR_EARLY || m_axis_tdata[34:33] == ERR_SHORT)
      |-> m_axis_tlast)
    else $error("truncation code before packet end");

  // input can always move when the output slot is free
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind chunk_header_varint_parser chvp_checker u_chvp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
